### rtl/assert_macros.svh
// assertion macros shared by the tokenizer rtl
// no dependencies; compiled away when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define STOK_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("tokenizer assertion failed");

`define STOK_ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("tokenizer forbidden condition seen");

`else

`define STOK_ASSERT(label, clk, rst_n, prop)
`define STOK_ASSERT_NEVER(label, clk, rst_n, cond)

`endif

`endif

### rtl/stok_pkg.sv
// shared types and constants for the script tokenizer
// no dependencies
package stok_pkg;

    localparam int TOKEN_CAPACITY = 128;
    localparam int LINE_BITS      = 16;
    localparam int TLEN_W         = $clog2(TOKEN_CAPACITY);
    localparam int LINE_OUT_W     = 16;

    localparam int FIFO_DEPTH = 8;
    localparam int MAX_PUSH   = 3;
    localparam int FPTR_W     = $clog2(FIFO_DEPTH);
    localparam int FCNT_W     = FPTR_W + 1;

    localparam logic [1:0] KIND_BYTE = 2'd0;
    localparam logic [1:0] KIND_END  = 2'd1;
    localparam logic [1:0] KIND_EOS  = 2'd2;
    localparam logic [1:0] KIND_ERR  = 2'd3;

    localparam logic [1:0] ERR_NONE  = 2'd0;
    localparam logic [1:0] ERR_QUOTE = 2'd1;
    localparam logic [1:0] ERR_LONG  = 2'd2;

    typedef struct packed {
        logic [1:0]            kind;
        logic [7:0]            out_byte;
        logic                  first_of_token;
        logic                  line_break_before;
        logic [LINE_OUT_W-1:0] line_number;
        logic [1:0]            error_code;
        logic                  last_of_run;
    } stok_item_t;

    typedef struct packed {
        logic [1:0]            count;
        stok_item_t [MAX_PUSH-1:0] items;
    } stok_push_t;

endpackage

### rtl/script_tokenizer.sv
// script tokenizer: one script byte in, token bytes, token ends, end and errors out
// results of an item are registered in the result queue as it is accepted and offered on m_ from there
// throughput: one byte per cycle while the 8-entry result queue has room for three;
// results leave at one per cycle while m_tready is high, so bytes giving two or three results drain in turn
// reset (aresetn low, synchronous): scanner between tokens, line 1, queue empty
// depends on stok_pkg, stok_scan, stok_fifo
module script_tokenizer (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    input  logic        s_tuser,   // [0] begin_script
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [7:0] out_byte, [8] first_of_token,
                                   // [9] line_break_before, [25:10] line_number,
                                   // [27:26] error_code, [31:28] zero
    output logic [1:0]  m_tuser,   // [1:0] kind
    output logic        m_tlast    // last_of_run
);
    import stok_pkg::*;

    stok_push_t push;
    stok_item_t head;
    logic       room;
    logic       in_accept;

    assign s_tready  = room;
    assign in_accept = s_tvalid && room;

    stok_scan u_scan (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_accept    (in_accept),
        .in_byte      (s_tdata),
        .begin_script (s_tuser),
        .push         (push)
    );

    stok_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (in_accept),
        .wr       (push),
        .has_room (room),
        .rd_valid (m_tvalid),
        .rd_ready (m_tready),
        .rd_item  (head)
    );

    assign m_tdata = {4'd0, head.error_code, head.line_number, head.line_break_before,
                      head.first_of_token, head.out_byte};
    assign m_tuser = head.kind;
    assign m_tlast = head.last_of_run;

endmodule

### rtl/stok_scan.sv
// scanner state and per-byte decode into up to three result items
// depends on stok_pkg and assert_macros.svh
`include "assert_macros.svh"

module stok_scan (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_accept,
    input  logic [7:0]        in_byte,
    input  logic              begin_script,
    output stok_pkg::stok_push_t push
);
    import stok_pkg::*;

    localparam logic [2:0] M_BETWEEN = 3'd0;
    localparam logic [2:0] M_SLASH   = 3'd1;
    localparam logic [2:0] M_COMMENT = 3'd2;
    localparam logic [2:0] M_PLAIN   = 3'd3;
    localparam logic [2:0] M_QUOTED  = 3'd4;
    localparam logic [2:0] M_HALTED  = 3'd5;

    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_QUOTE = 8'h22;

    localparam logic [TLEN_W-1:0]    LEN_ZERO = '0;
    localparam logic [TLEN_W-1:0]    LEN_ONE  = TLEN_W'(1);
    localparam logic [TLEN_W-1:0]    LEN_LAST = TLEN_W'(TOKEN_CAPACITY - 1);
    localparam logic [LINE_BITS-1:0] LINE_ONE = LINE_BITS'(1);
    localparam logic [LINE_BITS-1:0] LINE_MAX = {LINE_BITS{1'b1}};

    logic [2:0]           mode_reg, mode_next, mode_cur;
    logic [TLEN_W-1:0]    len_reg, len_next, len_cur, app_len;
    logic [LINE_BITS-1:0] line_reg, line_next, line_cur, line_inc;
    logic                 cross_reg, cross_next, cross_cur;
    logic                 is_zero, is_nl, is_ws, is_slash, is_quote;
    logic                 do_append, do_end, stop_any;
    logic [7:0]           app_byte;
    logic [1:0]           n;
    stok_item_t [MAX_PUSH-1:0] items;

    function automatic stok_item_t mk(input logic [1:0] kind, input logic [7:0] b,
                                      input logic first, input logic lbb,
                                      input logic [1:0] err,
                                      input logic [LINE_BITS-1:0] line);
        stok_item_t r;
        r.kind              = kind;
        r.out_byte          = b;
        r.first_of_token    = first;
        r.line_break_before = lbb;
        r.line_number       = LINE_OUT_W'(line);
        r.error_code        = err;
        r.last_of_run       = 1'b0;
        return r;
    endfunction

    always_comb begin
        mode_cur  = begin_script ? M_BETWEEN : mode_reg;
        len_cur   = begin_script ? LEN_ZERO  : len_reg;
        line_cur  = begin_script ? LINE_ONE  : line_reg;
        cross_cur = begin_script ? 1'b0      : cross_reg;
        line_inc  = (line_cur == LINE_MAX) ? line_cur : line_cur + LINE_ONE;

        is_zero  = (in_byte == 8'd0);
        is_nl    = (in_byte == CH_NL);
        is_ws    = (in_byte <= CH_SPACE);
        is_slash = (in_byte == CH_SLASH);
        is_quote = (in_byte == CH_QUOTE);

        mode_next  = mode_cur;
        len_next   = len_cur;
        line_next  = line_cur;
        cross_next = cross_cur;
        items      = '0;
        n          = 2'd0;
        do_append  = 1'b0;
        do_end     = 1'b0;
        app_len    = len_cur;
        app_byte   = in_byte;

        unique case (mode_cur)
            M_BETWEEN: begin
                priority if (is_zero) begin
                    items[0]  = mk(KIND_EOS, 8'd0, 1'b0, 1'b0, ERR_NONE, line_cur);
                    n         = 2'd1;
                    mode_next = M_HALTED;
                end else if (is_nl) begin
                    line_next  = line_inc;
                    cross_next = 1'b1;
                end else if (is_ws) begin
                    mode_next = M_BETWEEN;
                end else if (is_slash) begin
                    mode_next = M_SLASH;
                end else if (is_quote) begin
                    mode_next = M_QUOTED;
                    len_next  = LEN_ZERO;
                end else begin
                    mode_next = M_PLAIN;
                    app_len   = LEN_ZERO;
                    do_append = 1'b1;
                end
            end
            M_SLASH: begin
                if (is_slash) begin
                    mode_next = M_COMMENT;
                end else begin
                    // held slash becomes the first byte of a plain token
                    items[0]  = mk(KIND_BYTE, CH_SLASH, 1'b1, cross_cur, ERR_NONE, line_cur);
                    n         = 2'd1;
                    mode_next = M_PLAIN;
                    len_next  = LEN_ONE;
                    app_len   = LEN_ONE;
                    do_append = !is_ws;
                    do_end    = is_ws;
                end
            end
            M_COMMENT: begin
                if (is_zero) begin
                    items[0]  = mk(KIND_EOS, 8'd0, 1'b0, 1'b0, ERR_NONE, line_cur);
                    n         = 2'd1;
                    mode_next = M_HALTED;
                end else if (is_nl) begin
                    line_next  = line_inc;
                    cross_next = 1'b1;
                    mode_next  = M_BETWEEN;
                end
            end
            M_PLAIN: begin
                do_append = !is_ws;
                do_end    = is_ws;
            end
            M_QUOTED: begin
                priority if (is_zero) begin
                    items[0]  = mk(KIND_ERR, 8'd0, 1'b0, 1'b0, ERR_QUOTE, line_cur);
                    n         = 2'd1;
                    mode_next = M_HALTED;
                end else if (is_quote) begin
                    items[0]   = mk(KIND_END, 8'd0, 1'b0, cross_cur, ERR_NONE, line_cur);
                    n          = 2'd1;
                    cross_next = 1'b0;
                    len_next   = LEN_ZERO;
                    mode_next  = M_BETWEEN;
                end else begin
                    do_append = 1'b1;
                end
            end
            default: begin
                mode_next = M_HALTED;
            end
        endcase

        if (do_append) begin
            if (app_len == LEN_LAST) begin
                items[n]  = mk(KIND_ERR, 8'd0, 1'b0, 1'b0, ERR_LONG, line_cur);
                mode_next = M_HALTED;
            end else begin
                items[n] = mk(KIND_BYTE, app_byte, app_len == LEN_ZERO, cross_cur,
                              ERR_NONE, line_cur);
                len_next = app_len + LEN_ONE;
            end
            n = n + 2'd1;
        end

        if (do_end) begin
            // whitespace or zero closes a plain token
            items[n]   = mk(KIND_END, 8'd0, 1'b0, cross_cur, ERR_NONE, line_cur);
            n          = n + 2'd1;
            cross_next = 1'b0;
            len_next   = LEN_ZERO;
            mode_next  = M_BETWEEN;
            if (is_zero) begin
                items[n]  = mk(KIND_EOS, 8'd0, 1'b0, 1'b0, ERR_NONE, line_cur);
                n         = n + 2'd1;
                mode_next = M_HALTED;
            end else if (is_nl) begin
                line_next  = line_inc;
                cross_next = 1'b1;
            end
        end

        stop_any = 1'b0;
        for (int i = 0; i < MAX_PUSH; i++) begin
            items[i].last_of_run = (2'(i) + 2'd1 == n);
            if ((2'(i) < n) && (items[i].kind == KIND_EOS || items[i].kind == KIND_ERR)) begin
                stop_any = 1'b1;
            end
        end

        push.count = n;
        push.items = items;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= M_BETWEEN;
            len_reg   <= LEN_ZERO;
            line_reg  <= LINE_ONE;
            cross_reg <= 1'b0;
        end else if (in_accept) begin
            mode_reg  <= mode_next;
            len_reg   <= len_next;
            line_reg  <= line_next;
            cross_reg <= cross_next;
        end
    end

    `STOK_ASSERT(a_stop_halts, aclk, aresetn, in_accept && stop_any |=> mode_reg == M_HALTED)
    `STOK_ASSERT_NEVER(a_halted_quiet, aclk, aresetn,
        mode_reg == M_HALTED && !begin_script && push.count != 2'd0)

endmodule

### rtl/stok_fifo.sv
// result queue: takes up to three items per cycle while it has room, gives one per cycle while rd_ready is high
// depends on stok_pkg and assert_macros.svh
`include "assert_macros.svh"

module stok_fifo (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 wr_en,
    input  stok_pkg::stok_push_t wr,
    output logic                 has_room,
    output logic                 rd_valid,
    input  logic                 rd_ready,
    output stok_pkg::stok_item_t rd_item
);
    import stok_pkg::*;

    stok_item_t          mem_reg [FIFO_DEPTH];
    logic [FPTR_W-1:0]   wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [FCNT_W-1:0]   count_reg, count_next;
    logic [1:0]          push_n;
    logic                pop;

    always_comb begin
        push_n      = wr_en ? wr.count : 2'd0;
        rd_valid    = (count_reg != '0);
        pop         = rd_valid && rd_ready;
        rd_item     = mem_reg[rd_ptr_reg];
        has_room    = (count_reg <= FCNT_W'(FIFO_DEPTH - MAX_PUSH));
        wr_ptr_next = wr_ptr_reg + FPTR_W'(push_n);
        rd_ptr_next = rd_ptr_reg + FPTR_W'(pop);
        count_next  = count_reg + FCNT_W'(push_n) - FCNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < MAX_PUSH; i++) begin
            if (2'(i) < push_n) begin
                mem_reg[wr_ptr_reg + FPTR_W'(i)] <= wr.items[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `STOK_ASSERT_NEVER(a_no_overflow, aclk, aresetn, count_reg > FCNT_W'(FIFO_DEPTH))
    `STOK_ASSERT(a_pop_drains, aclk, aresetn,
        pop && push_n == 2'd0 |=> count_reg == $past(count_reg) - FCNT_W'(1))

endmodule
